// ===== rtl/brpc_pkg.sv =====
// ============================================================================
// brpc_pkg
// Shared types, event codes and constants for the button relay pairing block.
// ============================================================================
package brpc_pkg;

    // Width of the wrapping millisecond time base used for durations
    localparam int TIME_BITS = 32;

    localparam int CFG_BITS     = 16;
    localparam int CFG_IDX_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_LONG_PRESS   = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MAX_PRESS    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DOUBLE_CLICK = 2'd2;

    // Configuration reset values
    localparam logic [CFG_BITS-1:0] LONG_PRESS_RST   = 16'd5000;
    localparam logic [CFG_BITS-1:0] MAX_PRESS_RST    = 16'd10000;
    localparam logic [CFG_BITS-1:0] DOUBLE_CLICK_RST = 16'd300;

    // Event kinds
    localparam logic [2:0] KIND_BUTTON     = 3'd0;
    localparam logic [2:0] KIND_SWITCH_ONE = 3'd1;
    localparam logic [2:0] KIND_SWITCH_TWO = 3'd2;
    localparam logic [2:0] KIND_JOIN_OK    = 3'd3;
    localparam logic [2:0] KIND_JOIN_FAIL  = 3'd4;
    localparam logic [2:0] KIND_LEFT       = 3'd5;
    localparam logic [2:0] KIND_READY      = 3'd6;

    // Click classes
    localparam logic [2:0] CLICK_NONE     = 3'd0;
    localparam logic [2:0] CLICK_SINGLE   = 3'd1;
    localparam logic [2:0] CLICK_DOUBLE   = 3'd2;
    localparam logic [2:0] CLICK_LONG     = 3'd3;
    localparam logic [2:0] CLICK_OVERLONG = 3'd4;

    // LED modes
    localparam logic [1:0] LED_PAIRING = 2'd0;
    localparam logic [1:0] LED_JOINED  = 2'd1;
    localparam logic [1:0] LED_READY   = 2'd2;
    localparam logic [1:0] LED_IDLE    = 2'd3;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic [2:0]  kind;
        logic        level;
        logic [31:0] time_ms;
        logic        start_ok;
    } t_in_item;

    typedef struct packed {
        logic       relay_one;
        logic       relay_two;
        logic       pairing;
        logic [2:0] click_class;
        logic [1:0] led_mode;
    } t_out_item;

    typedef struct packed {
        logic [CFG_BITS-1:0] long_press_ms;
        logic [CFG_BITS-1:0] max_press_ms;
        logic [CFG_BITS-1:0] double_click_ms;
    } t_cfg;

endpackage

// ===== rtl/button_relay_pairing_controller.sv =====
// ============================================================================
// button_relay_pairing_controller
// Button click / long-press classifier driving two relays and pairing mode.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one timestamped
//   event per transaction: button level, switch levels or network signals.
//   Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly one
//   result transaction per event: relay drives, pairing flag, click class and
//   status LED mode.
//   Configuration: write i_cfg_data into register i_cfg_idx while i_cfg_we is
//   high; write only while no event is in flight.
//   An event passes through the input register, then the result register.
//   Throughput: one event per cycle while the receiver does not stall; the
//   decode between the two registers is two 32-bit subtracts and three compares.
//   When the receiver stalls, the result register holds and the input register
//   may still take one more event; o_in_stall rises only when both are full.
//   Reset (synchronous, active low) clears both pipeline stages, all relay,
//   pairing and network state, and restores the default thresholds.
// ============================================================================
module button_relay_pairing_controller import brpc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_in_item                i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_out_item               o_out_data,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    t_cfg      cfg;
    t_out_item res;

    logic      r_s1_valid;
    t_in_item  r_s1_data;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic      advance;
    logic      fire;

    // Result register can take a new value when empty or being drained
    assign advance    = !r_out_valid || !i_out_stall;
    // Event in the input register moves into the result register
    assign fire       = r_s1_valid && advance;
    // Hold off the sender only when the input register cannot move
    assign o_in_stall = r_s1_valid && !advance;

    brpc_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    brpc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_ev    (r_s1_data),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    // Input register: load on accept, drop when the event advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_s1_data <= i_in_data;
        end
    end

    // Result register: hold while stalled, advance otherwise
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== rtl/brpc_cfg.sv =====
// ============================================================================
// brpc_cfg
// Configuration register file: press thresholds and double-click window.
// ============================================================================
module brpc_cfg import brpc_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data,
    output t_cfg                    o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_LONG_PRESS:   n_cfg.long_press_ms   = i_cfg_data;
                CFG_MAX_PRESS:    n_cfg.max_press_ms    = i_cfg_data;
                CFG_DOUBLE_CLICK: n_cfg.double_click_ms = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_press_ms   <= LONG_PRESS_RST;
            r_cfg.max_press_ms    <= MAX_PRESS_RST;
            r_cfg.double_click_ms <= DOUBLE_CLICK_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/brpc_core.sv =====
// ============================================================================
// brpc_core
// Event decode, press timing and relay/pairing/network state for one event.
// ============================================================================
module brpc_core import brpc_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_fire,
    input  t_in_item  i_ev,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);

    logic  r_held, n_held;
    t_time r_press_start, n_press_start;
    t_time r_last_click, n_last_click;
    logic  r_relay_one, n_relay_one;
    logic  r_relay_two, n_relay_two;
    logic  r_pairing, n_pairing;
    logic  r_joined, n_joined;
    logic  r_ready, n_ready;

    t_time      now;
    t_time      held_for;
    t_time      gap;
    logic [2:0] cls;

    assign now      = TIME_BITS'(i_ev.time_ms);
    assign held_for = now - r_press_start;
    assign gap      = now - r_last_click;

    always_comb begin
        n_held        = r_held;
        n_press_start = r_press_start;
        n_last_click  = r_last_click;
        n_relay_one   = r_relay_one;
        n_relay_two   = r_relay_two;
        n_pairing     = r_pairing;
        n_joined      = r_joined;
        n_ready       = r_ready;
        cls           = CLICK_NONE;
        case (i_ev.kind)
            KIND_BUTTON: begin
                if (!i_ev.level) begin
                    // press: keep the first start time while held
                    if (!r_held) begin
                        n_held        = 1'b1;
                        n_press_start = now;
                    end
                end else if (r_held) begin
                    n_held = 1'b0;
                    if (held_for < TIME_BITS'(i_cfg.long_press_ms)) begin
                        n_last_click = now;
                        if (gap < TIME_BITS'(i_cfg.double_click_ms)) begin
                            n_relay_two = !r_relay_two;
                            cls         = CLICK_DOUBLE;
                        end else begin
                            n_relay_one = !r_relay_one;
                            cls         = CLICK_SINGLE;
                        end
                    end else if (held_for < TIME_BITS'(i_cfg.max_press_ms)) begin
                        n_pairing = r_pairing ? 1'b0 : i_ev.start_ok;
                        cls       = CLICK_LONG;
                    end else begin
                        cls = CLICK_OVERLONG;
                    end
                end
            end
            KIND_SWITCH_ONE: n_relay_one = i_ev.level;
            KIND_SWITCH_TWO: n_relay_two = i_ev.level;
            KIND_JOIN_OK: begin
                n_joined  = 1'b1;
                n_ready   = 1'b1;
                n_pairing = 1'b0;
            end
            KIND_JOIN_FAIL: n_ready  = 1'b0;
            KIND_LEFT:      n_joined = 1'b0;
            KIND_READY:     n_ready  = 1'b1;
            default: begin
                n_held = r_held;
            end
        endcase
    end

    always_comb begin
        o_res.relay_one   = n_relay_one;
        o_res.relay_two   = n_relay_two;
        o_res.pairing     = n_pairing;
        o_res.click_class = cls;
        if (n_pairing) begin
            o_res.led_mode = LED_PAIRING;
        end else if (n_joined) begin
            o_res.led_mode = LED_JOINED;
        end else if (n_ready) begin
            o_res.led_mode = LED_READY;
        end else begin
            o_res.led_mode = LED_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held        <= 1'b0;
            r_press_start <= '0;
            r_last_click  <= '0;
            r_relay_one   <= 1'b0;
            r_relay_two   <= 1'b0;
            r_pairing     <= 1'b0;
            r_joined      <= 1'b0;
            r_ready       <= 1'b0;
        end else if (i_fire) begin
            r_held        <= n_held;
            r_press_start <= n_press_start;
            r_last_click  <= n_last_click;
            r_relay_one   <= n_relay_one;
            r_relay_two   <= n_relay_two;
            r_pairing     <= n_pairing;
            r_joined      <= n_joined;
            r_ready       <= n_ready;
        end
    end

`ifndef SYNTH
    a_pairing_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pairing) |-> $past(i_fire && i_ev.start_ok && i_ev.kind == KIND_BUTTON))
        else $error("pairing entered without a long press and start_ok");

    a_press_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_held) |-> (r_press_start == TIME_BITS'($past(i_ev.time_ms))))
        else $error("press start time not captured on press");

    a_relay_two_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_relay_two) |->
            $past(i_fire && (i_ev.kind == KIND_BUTTON || i_ev.kind == KIND_SWITCH_TWO)))
        else $error("relay two changed on an unrelated event");
`endif

endmodule

// ===== tb/button_relay_pairing_controller_tb.sv =====
// ============================================================================
// button_relay_pairing_controller_tb
// Self-checking bench for the button relay pairing controller: a directed
// table of events, then per-threshold random phases of press/release
// sequences, switch and network events and noise, all checked in order
// against an in-bench model of the click, relay, pairing and LED logic.
// ============================================================================
module button_relay_pairing_controller_tb import brpc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // Event kind left unused by the block; it must report state unchanged
    localparam logic [2:0] KIND_UNUSED = 3'd7;

    localparam int HOLD_AT     = 150;   // transaction count that starts the long hold-off
    localparam int HOLD_CYCLES = 64;    // length of the hold-off, in cycles
    localparam int CALM_FROM   = 360;   // window with no idling on either side
    localparam int CALM_TO     = 420;
    localparam int PHASE_ITEMS = 80;
    localparam int N_PHASES    = 8;
    localparam int DIR_N       = 26;
    localparam int MAX_REPORTS = 10;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic                    clk      = 1'b0;
    logic                    rst_n    = 1'b0;
    logic                    ev_valid = 1'b0;
    logic                    ev_stall;
    t_in_item                ev_data  = '0;
    logic                    res_valid;
    logic                    res_stall = 1'b0;
    t_out_item               res_data;
    logic                    cfg_we   = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx  = CFG_LONG_PRESS;
    logic [CFG_BITS-1:0]     cfg_data = '0;

    button_relay_pairing_controller dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (ev_valid),
        .o_in_stall  (ev_stall),
        .i_in_data   (ev_data),
        .o_out_valid (res_valid),
        .i_out_stall (res_stall),
        .o_out_data  (res_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    t_out_item pending_results [$];     // one expected result per accepted event
    int        sent_count = 0;
    int        err_count  = 0;
    logic      calm;
    t_time     clock_ms;                // running time base for well-formed sequences

    assign calm = (sent_count >= CALM_FROM) && (sent_count < CALM_TO);

    // Model copy of the thresholds and of the controller state
    t_cfg  limits;
    logic  btn_held;
    t_time press_t0;
    t_time last_click_t;
    logic  relay1_q, relay2_q, pairing_q, joined_q, ready_q;

    // ------------------------------------------------------------------------
    // Model: advance the controller state by one event and return its result
    // ------------------------------------------------------------------------
    function automatic t_out_item predict_event(input t_in_item ev);
        t_out_item  r;
        t_time      held;
        t_time      gap;
        logic [2:0] cls;
        cls = CLICK_NONE;
        case (ev.kind)
            KIND_BUTTON: begin
                if (!ev.level) begin
                    // a second press while held keeps the first start time
                    if (!btn_held) begin
                        btn_held = 1'b1;
                        press_t0 = ev.time_ms;
                    end
                end else if (btn_held) begin
                    btn_held = 1'b0;
                    held = ev.time_ms - press_t0;       // wraps mod 2^32
                    gap  = ev.time_ms - last_click_t;
                    if (held < t_time'(limits.long_press_ms)) begin
                        if (gap < t_time'(limits.double_click_ms)) begin
                            relay2_q = !relay2_q;
                            cls = CLICK_DOUBLE;
                        end else begin
                            relay1_q = !relay1_q;
                            cls = CLICK_SINGLE;
                        end
                        last_click_t = ev.time_ms;
                    end else if (held < t_time'(limits.max_press_ms)) begin
                        // leave pairing unconditionally, enter only if start is ok
                        pairing_q = pairing_q ? 1'b0 : ev.start_ok;
                        cls = CLICK_LONG;
                    end else begin
                        cls = CLICK_OVERLONG;
                    end
                end
            end
            KIND_SWITCH_ONE: relay1_q = ev.level;
            KIND_SWITCH_TWO: relay2_q = ev.level;
            KIND_JOIN_OK: begin
                joined_q  = 1'b1;
                ready_q   = 1'b1;
                pairing_q = 1'b0;
            end
            KIND_JOIN_FAIL: ready_q  = 1'b0;
            KIND_LEFT:      joined_q = 1'b0;
            KIND_READY:     ready_q  = 1'b1;
            default: ;
        endcase
        r.relay_one   = relay1_q;
        r.relay_two   = relay2_q;
        r.pairing     = pairing_q;
        r.click_class = cls;
        if (pairing_q)     r.led_mode = LED_PAIRING;
        else if (joined_q) r.led_mode = LED_JOINED;
        else if (ready_q)  r.led_mode = LED_READY;
        else               r.led_mode = LED_IDLE;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Directed table; rows with typed set carry a hand-written expectation,
    // the rest are checked against the model
    // ------------------------------------------------------------------------
    typedef struct packed {
        t_in_item  ev;
        logic      typed;
        t_out_item want;
    } t_dir_row;

    localparam t_out_item OUT_IDLE  = '{1'b0, 1'b0, 1'b0, CLICK_NONE, LED_IDLE};
    localparam t_out_item OUT_MODEL = '0;

    t_dir_row dir_rows [DIR_N] = '{
        // unknown kind right after reset: all clear, idle LED
        '{'{KIND_UNUSED, 1'b1, 32'd0, 1'b1}, 1'b1, OUT_IDLE},
        // release while not held
        '{'{KIND_BUTTON, 1'b1, 32'd100, 1'b0}, 1'b1, OUT_IDLE},
        // press, then a press while already held
        '{'{KIND_BUTTON, 1'b0, 32'd16, 1'b0}, 1'b1, OUT_IDLE},
        '{'{KIND_BUTTON, 1'b0, 32'd32, 1'b1}, 1'b1, OUT_IDLE},
        // first click near time 0 counts as a double click
        '{'{KIND_BUTTON, 1'b1, 32'd116, 1'b0}, 1'b1,
          '{1'b0, 1'b1, 1'b0, CLICK_DOUBLE, LED_IDLE}},
        // single, then double click
        '{'{KIND_BUTTON, 1'b0, 32'd1000, 1'b0}, 1'b0, OUT_MODEL},
        '{'{KIND_BUTTON, 1'b1, 32'd1500, 1'b0}, 1'b0, OUT_MODEL},
        '{'{KIND_BUTTON, 1'b0, 32'd1600, 1'b0}, 1'b0, OUT_MODEL},
        '{'{KIND_BUTTON, 1'b1, 32'd1700, 1'b0}, 1'b0, OUT_MODEL},
        // long press exactly at the long time, start refused
        '{'{KIND_BUTTON, 1'b0, 32'd10000, 1'b0}, 1'b0, OUT_MODEL},
        '{'{KIND_BUTTON, 1'b1, 32'd15000, 1'b0}, 1'b0, OUT_MODEL},
        // long press just under the max time, start accepted
        '{'{KIND_BUTTON, 1'b0, 32'd20000, 1'b1}, 1'b0, OUT_MODEL},
        '{'{KIND_BUTTON, 1'b1, 32'd29999, 1'b1}, 1'b0, OUT_MODEL},
        // press exactly at the max time is ignored
        '{'{KIND_BUTTON, 1'b0, 32'd30000, 1'b0}, 1'b0, OUT_MODEL},
        '{'{KIND_BUTTON, 1'b1, 32'd40000, 1'b1}, 1'b1,
          '{1'b1, 1'b0, 1'b1, CLICK_OVERLONG, LED_PAIRING}},
        // switches set the relays to the level
        '{'{KIND_SWITCH_ONE, 1'b0, 32'd40100, 1'b0}, 1'b0, OUT_MODEL},
        '{'{KIND_SWITCH_TWO, 1'b1, 32'd40200, 1'b1}, 1'b0, OUT_MODEL},
        // network signals and LED priority
        '{'{KIND_READY, 1'b0, 32'd40300, 1'b0}, 1'b0, OUT_MODEL},
        '{'{KIND_JOIN_OK, 1'b1, 32'd40400, 1'b1}, 1'b0, OUT_MODEL},
        '{'{KIND_JOIN_FAIL, 1'b0, 32'd40500, 1'b0}, 1'b0, OUT_MODEL},
        '{'{KIND_LEFT, 1'b1, 32'd40600, 1'b0}, 1'b0, OUT_MODEL},
        '{'{KIND_READY, 1'b1, 32'd40700, 1'b1}, 1'b0, OUT_MODEL},
        // press across the time wrap
        '{'{KIND_BUTTON, 1'b0, 32'hFFFF_FF00, 1'b0}, 1'b0, OUT_MODEL},
        '{'{KIND_BUTTON, 1'b1, 32'h0000_0010, 1'b1}, 1'b0, OUT_MODEL},
        // zero-length press at the top of the time range
        '{'{KIND_BUTTON, 1'b0, 32'hFFFF_FFFF, 1'b1}, 1'b0, OUT_MODEL},
        '{'{KIND_BUTTON, 1'b1, 32'hFFFF_FFFF, 1'b0}, 1'b0, OUT_MODEL}
    };

    // ------------------------------------------------------------------------
    // Sender: offer one event, hold it until accepted, record its result,
    // then idle at random
    // ------------------------------------------------------------------------
    task automatic offer_event(input t_in_item ev, input logic typed, input t_out_item want);
        t_out_item pred;
        ev_data  <= ev;
        ev_valid <= 1'b1;
        @(posedge clk);
        while (ev_stall) @(posedge clk);
        pred = predict_event(ev);
        pending_results.push_back(typed ? want : pred);
        sent_count++;
        if (!calm && $urandom_range(0, 99) < 15) begin
            ev_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    // Drop valid and wait until every expected result has come back
    task automatic drain_events();
        ev_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Write all three thresholds on back-to-back cycles and mirror them
    task automatic program_limits(input t_cfg c);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_LONG_PRESS;
        cfg_data <= c.long_press_ms;
        @(posedge clk);
        cfg_idx  <= CFG_MAX_PRESS;
        cfg_data <= c.max_press_ms;
        @(posedge clk);
        cfg_idx  <= CFG_DOUBLE_CLICK;
        cfg_data <= c.double_click_ms;
        @(posedge clk);
        cfg_we   <= 1'b0;
        limits = c;
    endtask

    // ------------------------------------------------------------------------
    // One random phase: mostly press/release sequences with durations around
    // the thresholds, plus switch/network events and fully random noise
    // ------------------------------------------------------------------------
    task automatic run_phase(input int n_items);
        int       done_n;
        int       roll;
        t_time    press_at;
        t_time    dur;
        t_in_item ev;
        done_n = 0;
        while (done_n < n_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 70) begin
                // short gaps land in and around the double-click window
                if ($urandom_range(0, 1))
                    clock_ms += $urandom_range(0, 2 * int'(limits.double_click_ms) + 2);
                else
                    clock_ms += $urandom_range(0, 200000);
                press_at = clock_ms;
                ev = '{KIND_BUTTON, 1'b0, press_at, 1'($urandom)};
                offer_event(ev, 1'b0, OUT_MODEL);
                done_n++;
                if ($urandom_range(0, 9) == 0) begin
                    ev.time_ms = press_at + $urandom_range(0, 50);
                    offer_event(ev, 1'b0, OUT_MODEL);
                    done_n++;
                end
                case ($urandom_range(0, 7))
                    0: dur = '0;
                    1: dur = t_time'(limits.long_press_ms) - 1;
                    2: dur = t_time'(limits.long_press_ms);
                    3: dur = t_time'(limits.max_press_ms) - 1;
                    4: dur = t_time'(limits.max_press_ms);
                    5: dur = $urandom_range(0, limits.long_press_ms);
                    6: dur = $urandom_range(limits.long_press_ms, limits.max_press_ms);
                    default: dur = $urandom;
                endcase
                clock_ms = press_at + dur;
                ev = '{KIND_BUTTON, 1'b1, clock_ms, 1'($urandom)};
                offer_event(ev, 1'b0, OUT_MODEL);
                done_n++;
                // now and then a stray release with nothing held
                if ($urandom_range(0, 19) == 0) begin
                    offer_event(ev, 1'b0, OUT_MODEL);
                    done_n++;
                end
            end else if (roll < 85) begin
                clock_ms += $urandom_range(0, 1000);
                ev = '{KIND_SWITCH_ONE, 1'($urandom), clock_ms, 1'($urandom)};
                case ($urandom_range(0, 5))
                    0: ev.kind = KIND_SWITCH_ONE;
                    1: ev.kind = KIND_SWITCH_TWO;
                    2: ev.kind = KIND_JOIN_OK;
                    3: ev.kind = KIND_JOIN_FAIL;
                    4: ev.kind = KIND_LEFT;
                    default: ev.kind = KIND_READY;
                endcase
                offer_event(ev, 1'b0, OUT_MODEL);
                done_n++;
            end else begin
                ev = '{3'($urandom), 1'($urandom), t_time'($urandom), 1'($urandom)};
                offer_event(ev, 1'b0, OUT_MODEL);
                done_n++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Receiver pacing: random stalls, one long hold-off so the block fills
    // and stalls its input, and a calm window with no stalls
    // ------------------------------------------------------------------------
    initial begin : result_pacing
        int   hold_cnt;
        logic hold_done;
        hold_cnt  = 0;
        hold_done = 1'b0;
        forever begin
            @(posedge clk);
            if (!hold_done && sent_count >= HOLD_AT) begin
                res_stall <= 1'b1;
                hold_cnt++;
                if (hold_cnt == HOLD_CYCLES) hold_done = 1'b1;
            end else begin
                res_stall <= !calm && ($urandom_range(0, 99) < 15);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: compare each result transaction with the oldest
    // expectation, field by field
    // ------------------------------------------------------------------------
    always @(posedge clk) begin
        t_out_item want;
        if (rst_n && res_valid && !res_stall) begin
            if (pending_results.size() == 0) begin
                err_count++;
                if (err_count <= MAX_REPORTS)
                    $display("unexpected result transaction: %p", res_data);
            end else begin
                want = pending_results.pop_front();
                if (res_data.relay_one   !== want.relay_one   ||
                    res_data.relay_two   !== want.relay_two   ||
                    res_data.pairing     !== want.pairing     ||
                    res_data.click_class !== want.click_class ||
                    res_data.led_mode    !== want.led_mode) begin
                    err_count++;
                    if (err_count <= MAX_REPORTS)
                        $display("result mismatch at %0t: expected %p, got %p",
                                 $realtime, want, res_data);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        t_cfg phase_cfg [N_PHASES];
        // extremes, a normal setting, long not below max, the reset values, zero window, then random settings
        phase_cfg[0] = '{16'd0, 16'd0, 16'd0};
        phase_cfg[1] = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        phase_cfg[2] = '{16'd100, 16'd200, 16'd50};
        phase_cfg[3] = '{16'd300, 16'd100, 16'd200};
        phase_cfg[4] = '{LONG_PRESS_RST, MAX_PRESS_RST, DOUBLE_CLICK_RST};
        phase_cfg[5] = '{16'd20, 16'hFFFF, 16'd0};
        phase_cfg[6] = '{16'($urandom), 16'($urandom), 16'($urandom)};
        phase_cfg[7] = '{16'($urandom_range(0, 3000)), 16'($urandom_range(0, 8000)),
                         16'($urandom_range(0, 1000))};

        // model reset state mirrors the block's reset
        limits       = '{LONG_PRESS_RST, MAX_PRESS_RST, DOUBLE_CLICK_RST};
        btn_held     = 1'b0;
        press_t0     = '0;
        last_click_t = '0;
        relay1_q     = 1'b0;
        relay2_q     = 1'b0;
        pairing_q    = 1'b0;
        joined_q     = 1'b0;
        ready_q      = 1'b0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table runs on the reset thresholds
        for (int i = 0; i < DIR_N; i++)
            offer_event(dir_rows[i].ev, dir_rows[i].typed, dir_rows[i].want);

        // each phase: go idle, reprogram, then run random traffic
        for (int p = 0; p < N_PHASES; p++) begin
            drain_events();
            program_limits(phase_cfg[p]);
            clock_ms = $urandom;
            run_phase(PHASE_ITEMS);
        end

        drain_events();
        repeat (10) @(posedge clk);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hard stop far beyond the slowest legal run
    initial begin : watchdog
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
